[design/vlc_pkg.sv]
package vlc_pkg;

  // component width and derived widths
  localparam int CW    = 16;
  localparam int MAXW  = 16;
  localparam int SUM_W = 2 * CW;
  localparam int PW    = CW + MAXW;
  localparam int DIV_W = (2 * CW > PW) ? 2 * CW : PW;
  localparam int LW    = (CW > MAXW) ? CW : MAXW;

  localparam logic [MAXW-1:0] LIMIT_RESET = MAXW'(512);

  typedef struct packed {
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 was_clamped;
  } out_word_t;

  // word handed from the front to the back through the queue
  typedef struct packed {
    in_word_t               raw;
    logic [2:0][CW-1:0]     mag;
    logic [SUM_W-1:0]       sum;
  } mid_word_t;

endpackage

[design/vector_length_clamp.sv]
// channel   | handshake             | word
// ----------+-----------------------+--------------------------------------
// input     | push / full           | in_word  : in_x, in_y, in_z (Q8.8)
// result    | pop / empty           | out_word : out_x, out_y, out_z, flag
// config    | cfg_valid / cfg_ready | cfg_data : len_limit (Q8.8)
//
// One word enters per cycle and one result leaves per cycle when pop keeps up.
// A word passes through the front stages, the queue and the back root, product, divide
// and select stages; the bit-per-stage root and divide pipelines set the back depth.
// Synchronous reset empties every stage and loads len_limit with 512.
// Front and back stall independently; the two-entry queue absorbs the slack.
module vector_length_clamp import vlc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  in_word_t        in_word,
  output logic            empty,
  input  logic            pop,
  output out_word_t       out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [MAXW-1:0] cfg_data
);

  logic [MAXW-1:0] len_limit;
  logic            q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  mid_word_t       q_in_word, q_out_word;
  logic [CW-1:0]   abs_x, abs_y, abs_z;

  // register write is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_limit <= cfg_data;
    end
  end

  // front: magnitudes and sum of squares
  vlc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_valid (q_in_valid),
    .q_ready (q_in_ready),
    .q_word  (q_in_word)
  );

  // hold words between the halves
  vlc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_word  (q_in_word),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_word  (q_out_word)
  );

  // back: root, scale and select
  vlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_word    (q_out_word),
    .len_limit (len_limit),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

  assign abs_x = out_word.out_x[CW-1] ? -out_word.out_x : out_word.out_x;
  assign abs_y = out_word.out_y[CW-1] ? -out_word.out_y : out_word.out_y;
  assign abs_z = out_word.out_z[CW-1] ? -out_word.out_z : out_word.out_z;

  // a zero limit always drives a zero, flagged result
  a_zero_limit : assert property (@(posedge clk) disable iff (rst)
    !empty && len_limit == '0 |->
      out_word.was_clamped && out_word.out_x == '0 && out_word.out_y == '0 &&
      out_word.out_z == '0)
    else $error("zero limit gave a non-zero result");

  // a scaled component never exceeds the limit
  a_scaled_bound : assert property (@(posedge clk) disable iff (rst)
    !empty && out_word.was_clamped |->
      LW'(abs_x) <= LW'(len_limit) && LW'(abs_y) <= LW'(len_limit) &&
      LW'(abs_z) <= LW'(len_limit))
    else $error("scaled component above limit");

endmodule

[design/vlc_front.sv]
module vlc_front import vlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  output logic      q_valid,
  input  logic      q_ready,
  output mid_word_t q_word
);

  logic                   v1, v2, v3;
  logic                   enable;
  in_word_t               s1_raw, s2_raw, s3_raw;
  logic [2:0][CW-1:0]     s1_mag, s2_mag, s3_mag, in_mag;
  logic [2:0][SUM_W-1:0]  s2_sq;
  logic [SUM_W-1:0]       s3_sum;

  assign enable = !v3 || q_ready;
  assign full   = !enable;

  // take magnitudes of the two's complement components
  always_comb begin
    in_mag[0] = in_word.in_x[CW-1] ? (~in_word.in_x + CW'(1)) : in_word.in_x;
    in_mag[1] = in_word.in_y[CW-1] ? (~in_word.in_y + CW'(1)) : in_word.in_y;
    in_mag[2] = in_word.in_z[CW-1] ? (~in_word.in_z + CW'(1)) : in_word.in_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (enable) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      s1_raw <= in_word;
      s1_mag <= in_mag;
      s2_raw <= s1_raw;
      s2_mag <= s1_mag;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= SUM_W'(s1_mag[i]) * SUM_W'(s1_mag[i]);
      end
      s3_raw <= s2_raw;
      s3_mag <= s2_mag;
      s3_sum <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    end
  end

  assign q_valid    = v3;
  assign q_word.raw = s3_raw;
  assign q_word.mag = s3_mag;
  assign q_word.sum = s3_sum;

endmodule

[design/vlc_queue.sv]
module vlc_queue import vlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  mid_word_t wr_word,
  output logic      rd_valid,
  input  logic      rd_ready,
  output mid_word_t rd_word
);

  mid_word_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_word  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_word;
  end

endmodule

[design/vlc_back.sv]
module vlc_back import vlc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  mid_word_t       q_word,
  input  logic [MAXW-1:0] len_limit,
  output logic            empty,
  input  logic            pop,
  output out_word_t       out_word
);

  localparam int NS = 2 * CW + 2;

  logic [NS-1:0] v;
  logic          enable;

  // root stages
  in_word_t           sq_raw  [CW];
  logic [2:0][CW-1:0] sq_mag  [CW];
  logic [SUM_W-1:0]   sq_rem  [CW];
  logic [CW-1:0]      sq_root [CW];

  // product stage
  in_word_t              md_raw;
  logic [CW-1:0]         md_root;
  logic [2:0][DIV_W-1:0] md_rem;

  // divide stages
  in_word_t              dv_raw  [CW];
  logic [CW-1:0]         dv_root [CW];
  logic [2:0][DIV_W-1:0] dv_rem  [CW];
  logic [2:0][CW-1:0]    dv_q    [CW];

  out_word_t ow;

  assign enable  = !v[NS-1] || pop;
  assign q_ready = enable;
  assign empty   = !v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (enable) begin
      v <= {v[NS-2:0], q_valid};
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    localparam int B = CW - 1 - k;
    in_word_t           raw_in;
    logic [2:0][CW-1:0] mag_in;
    logic [SUM_W-1:0]   rem_in;
    logic [CW-1:0]      root_in;
    logic [SUM_W:0]     trial;

    if (k == 0) begin : g_first
      always_comb begin
        raw_in  = q_word.raw;
        mag_in  = q_word.mag;
        rem_in  = q_word.sum;
        root_in = '0;
      end
    end else begin : g_next
      always_comb begin
        raw_in  = sq_raw[k-1];
        mag_in  = sq_mag[k-1];
        rem_in  = sq_rem[k-1];
        root_in = sq_root[k-1];
      end
    end

    assign trial = ((SUM_W+1)'(root_in) << (B + 1)) + ((SUM_W+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (enable) begin
        sq_raw[k] <= raw_in;
        sq_mag[k] <= mag_in;
        if ({1'b0, rem_in} >= trial) begin
          sq_rem[k]  <= rem_in - trial[SUM_W-1:0];
          sq_root[k] <= root_in | (CW'(1) << B);
        end else begin
          sq_rem[k]  <= rem_in;
          sq_root[k] <= root_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      md_raw  <= sq_raw[CW-1];
      md_root <= sq_root[CW-1];
      for (int i = 0; i < 3; i++) begin
        md_rem[i] <= DIV_W'(PW'(sq_mag[CW-1][i]) * PW'(len_limit));
      end
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int B = CW - 1 - k;
    in_word_t              raw_in;
    logic [CW-1:0]         root_in;
    logic [2:0][DIV_W-1:0] rem_in;
    logic [2:0][CW-1:0]    q_in;
    logic [DIV_W-1:0]      dsr;

    if (k == 0) begin : g_first
      always_comb begin
        raw_in  = md_raw;
        root_in = md_root;
        rem_in  = md_rem;
        q_in    = '0;
      end
    end else begin : g_next
      always_comb begin
        raw_in  = dv_raw[k-1];
        root_in = dv_root[k-1];
        rem_in  = dv_rem[k-1];
        q_in    = dv_q[k-1];
      end
    end

    assign dsr = DIV_W'(root_in) << B;

    always_ff @(posedge clk) begin
      if (enable) begin
        dv_raw[k]  <= raw_in;
        dv_root[k] <= root_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dsr) begin
            dv_rem[k][i] <= rem_in[i] - dsr;
            dv_q[k][i]   <= q_in[i] | (CW'(1) << B);
          end else begin
            dv_rem[k][i] <= rem_in[i];
            dv_q[k][i]   <= q_in[i];
          end
        end
      end
    end
  end

  // pick the result: zero limit, zero length, scaled, or pass through
  always_ff @(posedge clk) begin
    if (enable) begin
      if (len_limit == '0) begin
        ow <= '{out_x: '0, out_y: '0, out_z: '0, was_clamped: 1'b1};
      end else if (dv_root[CW-1] == '0) begin
        ow <= '{out_x: '0, out_y: '0, out_z: '0, was_clamped: 1'b0};
      end else if (LW'(dv_root[CW-1]) > LW'(len_limit)) begin
        ow.out_x <= dv_raw[CW-1].in_x[CW-1] ? -dv_q[CW-1][0] : dv_q[CW-1][0];
        ow.out_y <= dv_raw[CW-1].in_y[CW-1] ? -dv_q[CW-1][1] : dv_q[CW-1][1];
        ow.out_z <= dv_raw[CW-1].in_z[CW-1] ? -dv_q[CW-1][2] : dv_q[CW-1][2];
        ow.was_clamped <= 1'b1;
      end else begin
        ow.out_x       <= dv_raw[CW-1].in_x;
        ow.out_y       <= dv_raw[CW-1].in_y;
        ow.out_z       <= dv_raw[CW-1].in_z;
        ow.was_clamped <= 1'b0;
      end
    end
  end

  assign out_word = ow;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import vlc_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_CYCLES  = 500;
  localparam int PHASE_ITEMS  = 200;

  typedef struct {
    in_word_t        w;
    logic [MAXW-1:0] lim;
    bit              known;
    out_word_t       res;
  } vec_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic            full;
  in_word_t        in_word = '0;
  logic            empty;
  logic            pop = 1'b0;
  out_word_t       out_word;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [MAXW-1:0] cfg_data = '0;

  // expected result words, oldest first
  out_word_t       clamped_q[$];
  logic [MAXW-1:0] limit_now = LIMIT_RESET;
  int              errors = 0;
  int              popped = 0;
  bit              calm = 1'b0;
  vec_row_t        rows[$];

  vector_length_clamp dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floored integer root, one result bit per step
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // length limit of one vector under the given maximum
  function automatic out_word_t clamp_predict(in_word_t w, logic [MAXW-1:0] lim);
    longint signed   c[3];
    longint unsigned m[3];
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    logic [CW-1:0]   o[3];
    out_word_t       r;
    c[0] = w.in_x;
    c[1] = w.in_y;
    c[2] = w.in_z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      sum += m[i] * m[i];
    end
    len = floor_root(sum);
    if (lim == 0) begin
      r = '0;
      r.was_clamped = 1'b1;
    end else if (len == 0) begin
      r = '0;
    end else if (len > lim) begin
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * lim) / len;
        o[i] = (c[i] < 0) ? CW'(-q) : CW'(q);
      end
      r.out_x = o[0];
      r.out_y = o[1];
      r.out_z = o[2];
      r.was_clamped = 1'b1;
    end else begin
      r.out_x = w.in_x;
      r.out_y = w.in_y;
      r.out_z = w.in_z;
      r.was_clamped = 1'b0;
    end
    return r;
  endfunction

  function automatic in_word_t vec(int x, int y, int z);
    in_word_t w;
    w.in_x = x[CW-1:0];
    w.in_y = y[CW-1:0];
    w.in_z = z[CW-1:0];
    return w;
  endfunction

  function automatic out_word_t res(int x, int y, int z, bit f);
    out_word_t r;
    r.out_x = x[CW-1:0];
    r.out_y = y[CW-1:0];
    r.out_z = z[CW-1:0];
    r.was_clamped = f;
    return r;
  endfunction

  function automatic void add_row(in_word_t w, logic [MAXW-1:0] lim, bit known,
                                  out_word_t r);
    vec_row_t v;
    v.w = w;
    v.lim = lim;
    v.known = known;
    v.res = r;
    rows.push_back(v);
  endfunction

  function automatic int rand_gap();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic in_word_t rand_vec();
    int x, y, z;
    case ($urandom_range(0, 3))
      0: begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end
      1: begin
        x = $urandom_range(0, 4000) - 2000;
        y = $urandom_range(0, 4000) - 2000;
        z = $urandom_range(0, 4000) - 2000;
      end
      2: begin
        x = 0;
        y = 0;
        z = 0;
        case ($urandom_range(0, 2))
          0: x = $urandom;
          1: y = $urandom;
          default: z = $urandom;
        endcase
      end
      default: begin
        x = $urandom_range(0, 1) ? $urandom_range(24000, 32767) : -$urandom_range(24000, 32768);
        y = $urandom_range(0, 1) ? $urandom_range(24000, 32767) : -$urandom_range(24000, 32768);
        z = $urandom_range(0, 1) ? $urandom_range(24000, 32767) : -$urandom_range(24000, 32768);
      end
    endcase
    return vec(x, y, z);
  endfunction

  // hold until every expected word is back, then let the pipeline settle
  task automatic drain();
    while (clamped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the maximum length while the block is idle
  task automatic write_limit(logic [MAXW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  // offer one word and hold it until taken; push stays high for back-to-back words
  task automatic send_vec(in_word_t w, bit known, out_word_t r);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    clamped_q.push_back(known ? r : clamp_predict(w, limit_now));
  endtask

  // stimulus
  initial begin
    logic [MAXW-1:0] lim;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset maximum of 512 first: zero, exact length, just over, floored length
    add_row(vec(0, 0, 0), 512, 1, res(0, 0, 0, 0));
    add_row(vec(512, 0, 0), 512, 1, res(512, 0, 0, 0));
    add_row(vec(513, 0, 0), 512, 1, res(512, 0, 0, 1));
    add_row(vec(-32768, 0, 0), 512, 1, res(-512, 0, 0, 1));
    add_row(vec(0, -1, 0), 512, 1, res(0, -1, 0, 0));
    add_row(vec(1, 1, 1), 512, 1, res(1, 1, 1, 0));
    add_row(vec(511, 10, 0), 512, 1, res(511, 10, 0, 0));
    add_row(vec(300, 300, 300), 512, 0, '0);
    add_row(vec(-32768, -32768, -32768), 512, 0, '0);
    add_row(vec(32767, 32767, 32767), 512, 0, '0);
    add_row(vec(32767, -32768, 1), 512, 0, '0);
    // zero maximum zeroes everything, the zero vector too
    add_row(vec(0, 0, 0), 0, 1, res(0, 0, 0, 1));
    add_row(vec(5, -5, 5), 0, 1, res(0, 0, 0, 1));
    add_row(vec(-32768, 32767, -1), 0, 1, res(0, 0, 0, 1));
    // largest maximum lets every vector through
    add_row(vec(-32768, -32768, -32768), 16'hFFFF, 1, res(-32768, -32768, -32768, 0));
    add_row(vec(32767, -32768, 1), 16'hFFFF, 1, res(32767, -32768, 1, 0));
    add_row(vec(0, 0, 0), 16'hFFFF, 1, res(0, 0, 0, 0));
    // smallest non-zero maximum
    add_row(vec(256, 0, 0), 1, 1, res(1, 0, 0, 1));
    add_row(vec(-3, 4, 0), 1, 1, res(0, 0, 0, 1));
    add_row(vec(0, 0, -1), 1, 1, res(0, 0, -1, 0));
    add_row(vec(-32768, 32767, 32767), 1, 0, '0);

    foreach (rows[i]) begin
      if (rows[i].lim != limit_now) begin
        push <= 1'b0;
        write_limit(rows[i].lim);
      end
      send_vec(rows[i].w, rows[i].known, rows[i].res);
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: lim = MAXW'($urandom_range(1, 1000));
        1: lim = MAXW'($urandom_range(0, 65535));
        2: lim = MAXW'(200);
        3: lim = MAXW'($urandom_range(100, 4000));
        4: lim = '0;
        5: lim = MAXW'($urandom_range(20000, 65535));
        default: lim = LIMIT_RESET;
      endcase
      push <= 1'b0;
      write_limit(lim);
      calm = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) send_vec(rand_vec(), 0, '0);
    end
    push <= 1'b0;
    calm = 1'b0;

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: check each taken word, then pick the next pop
  int stall_left = 0;
  bit held = 1'b0;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && pop && !empty) begin
      popped++;
      if (clamped_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = clamped_q.pop_front();
        if (out_word.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, out_word.out_x);
          errors++;
        end
        if (out_word.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, out_word.out_y);
          errors++;
        end
        if (out_word.out_z !== want.out_z) begin
          $error("out_z expected %0d actual %0d", want.out_z, out_word.out_z);
          errors++;
        end
        if (out_word.was_clamped !== want.was_clamped) begin
          $error("was_clamped expected %0b actual %0b", want.was_clamped,
                 out_word.was_clamped);
          errors++;
        end
      end
    end
    // one long hold-off so that the block backs up and stalls its input
    if (!held && popped == HOLD_AFTER) begin
      held = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      stall_left = $urandom_range(15, 60);
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 2);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog: count cycles in which no word moves on any channel
  int quiet = 0;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
